[design/mrfd_pkg.sv]
// shared types, constants and helpers for the meter response frame decoder
// used by meter_response_frame_decoder and its assertion checker
// no dependencies

package mrfd_pkg;

    localparam int unsigned FRAME_LEN = 28;
    localparam int unsigned SUM_LEN   = 26;
    localparam int unsigned POS_SAT   = 29;
    localparam int unsigned POS_W     = 5;
    localparam int unsigned PAIR_LO   = 14;
    localparam int unsigned PAIR_CNT  = 12;

    localparam logic [7:0] HDR_BYTE    = 8'h68;
    localparam logic [7:0] CTRL_BYTE   = 8'h91;
    localparam logic [7:0] END_BYTE    = 8'h16;
    localparam logic [7:0] DATA_OFFSET = 8'h33;

    localparam logic [POS_W-1:0] HDR0_POS = 5'd0;
    localparam logic [POS_W-1:0] HDR1_POS = 5'd7;
    localparam logic [POS_W-1:0] CTRL_POS = 5'd8;
    localparam logic [POS_W-1:0] CSUM_POS = 5'd26;
    localparam logic [POS_W-1:0] END_POS  = 5'd27;

    typedef enum logic [1:0] {
        STATUS_GOOD       = 2'd0,
        STATUS_BAD_LENGTH = 2'd1,
        STATUS_BAD_CHECK  = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       byte_present;
        logic       window_end;
    } item_t;

    typedef struct packed {
        logic [1:0]  frame_status;
        logic [14:0] voltage_tenths;
        logic [20:0] current_milliamps;
        logic [20:0] power_tenth_watts;
        logic [27:0] energy_hundredth_kwh;
    } result_t;

    // judged frame on its way to the scaling stage
    typedef struct packed {
        status_t                   status;
        logic [PAIR_CNT-1:0][7:0]  pairs;
    } judge_t;

    // two decimal digits of a data byte after removing the offset (0..165)
    function automatic logic [7:0] two_digits(input logic [7:0] raw);
        logic [7:0] d;
        d = raw - DATA_OFFSET;
        return ({4'd0, d[7:4]} * 8'd10) + {4'd0, d[3:0]};
    endfunction

endpackage

[design/meter_response_frame_decoder.sv]
// meter response frame decoder: byte collection, frame judgement, bcd scaling
// depends on mrfd_pkg
//
// throughput: one input transaction per cycle, no bubbles unless the result side stalls
// the three register stages (input, judge, result) are linked by the ready chain; only window-end items wait on judge
// reset: rst_n low clears position, sum, valids and the held readings to zero
// the frame byte store is not reset; only fully written frames are ever decoded

module meter_response_frame_decoder (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  mrfd_pkg::item_t  item,
    output logic             result_valid,
    input  logic             result_ready,
    output mrfd_pkg::result_t result
);

    // input stage
    logic                           in_valid_reg;
    mrfd_pkg::item_t                in_reg;

    // receive state
    logic [mrfd_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [7:0]                     sum_reg, sum_next;
    logic [7:0]                     frame_mem [mrfd_pkg::FRAME_LEN];

    // judge stage
    logic                           judge_valid_reg;
    mrfd_pkg::judge_t               judge_reg, judge_next;

    // result stage, also holds the last good readings
    logic                           result_valid_reg;
    mrfd_pkg::result_t              result_reg, result_next;

    logic                           in_go, judge_ready, judge_go, result_load;
    logic                           take_byte;
    logic [7:0]                     eff [mrfd_pkg::FRAME_LEN];

    // ready chain: each stage moves when it is empty or its content moves on
    assign result_load = judge_valid_reg && (!result_valid_reg || result_ready);
    assign judge_go    = result_load;
    assign judge_ready = !judge_valid_reg || judge_go;
    assign in_go       = in_valid_reg && (!in_reg.window_end || judge_ready);
    assign item_ready  = !in_valid_reg || in_go;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign take_byte = in_go && in_reg.byte_present;

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            in_reg <= item;
        end
    end

    // ------------------------------------------------------------------
    // byte position and running checksum after this transaction's byte
    // ------------------------------------------------------------------
    always_comb
    begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        if (in_reg.byte_present)
        begin
            if (pos_reg < mrfd_pkg::POS_W'(mrfd_pkg::SUM_LEN))
            begin
                sum_next = sum_reg + in_reg.rx_byte;
            end
            if (pos_reg < mrfd_pkg::POS_W'(mrfd_pkg::POS_SAT))
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            sum_reg <= '0;
        end
        else if (in_go)
        begin
            if (in_reg.window_end)
            begin
                // every judgement starts a fresh window
                pos_reg <= '0;
                sum_reg <= '0;
            end
            else
            begin
                pos_reg <= pos_next;
                sum_reg <= sum_next;
            end
        end
    end

    // frame store; bytes past the end of the frame are dropped
    always_ff @(posedge clk)
    begin
        if (take_byte && (pos_reg < mrfd_pkg::POS_W'(mrfd_pkg::FRAME_LEN)))
        begin
            frame_mem[pos_reg] <= in_reg.rx_byte;
        end
    end

    // ------------------------------------------------------------------
    // judgement: the byte arriving with window end is forwarded in
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int k = 0; k < int'(mrfd_pkg::FRAME_LEN); k++)
        begin
            if (in_reg.byte_present && (pos_reg == mrfd_pkg::POS_W'(k)))
            begin
                eff[k] = in_reg.rx_byte;
            end
            else
            begin
                eff[k] = frame_mem[k];
            end
        end
    end

    always_comb
    begin
        judge_next = '0;
        if (pos_next != mrfd_pkg::POS_W'(mrfd_pkg::FRAME_LEN))
        begin
            judge_next.status = mrfd_pkg::STATUS_BAD_LENGTH;
        end
        else if ((eff[mrfd_pkg::HDR0_POS] == mrfd_pkg::HDR_BYTE)
              && (eff[mrfd_pkg::HDR1_POS] == mrfd_pkg::HDR_BYTE)
              && (eff[mrfd_pkg::CTRL_POS] == mrfd_pkg::CTRL_BYTE)
              && (eff[mrfd_pkg::END_POS]  == mrfd_pkg::END_BYTE)
              && (eff[mrfd_pkg::CSUM_POS] == sum_next))
        begin
            judge_next.status = mrfd_pkg::STATUS_GOOD;
        end
        else
        begin
            judge_next.status = mrfd_pkg::STATUS_BAD_CHECK;
        end
        // digit pairs of bytes 14..25
        for (int k = 0; k < int'(mrfd_pkg::PAIR_CNT); k++)
        begin
            judge_next.pairs[k] = mrfd_pkg::two_digits(eff[k + int'(mrfd_pkg::PAIR_LO)]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            judge_valid_reg <= 1'b0;
        end
        else if (judge_ready)
        begin
            judge_valid_reg <= in_go && in_reg.window_end;
        end
    end

    always_ff @(posedge clk)
    begin
        if (judge_ready && in_go && in_reg.window_end)
        begin
            judge_reg <= judge_next;
        end
    end

    // ------------------------------------------------------------------
    // scaling: pairs weighted by powers of one hundred, low byte first
    // pair index = byte index - 14
    // ------------------------------------------------------------------
    always_comb
    begin
        result_next              = result_reg;
        result_next.frame_status = judge_reg.status;
        if (judge_reg.status == mrfd_pkg::STATUS_GOOD)
        begin
            result_next.voltage_tenths =
                  15'(judge_reg.pairs[1]) * 15'd100
                + 15'(judge_reg.pairs[0]);
            result_next.current_milliamps =
                  21'(judge_reg.pairs[4]) * 21'd10000
                + 21'(judge_reg.pairs[3]) * 21'd100
                + 21'(judge_reg.pairs[2]);
            result_next.power_tenth_watts =
                  21'(judge_reg.pairs[7]) * 21'd10000
                + 21'(judge_reg.pairs[6]) * 21'd100
                + 21'(judge_reg.pairs[5]);
            result_next.energy_hundredth_kwh =
                  28'(judge_reg.pairs[11]) * 28'd1000000
                + 28'(judge_reg.pairs[10]) * 28'd10000
                + 28'(judge_reg.pairs[9])  * 28'd100
                + 28'(judge_reg.pairs[8]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            if (!result_valid_reg || result_ready)
            begin
                result_valid_reg <= judge_valid_reg;
            end
            if (result_load)
            begin
                result_reg <= result_next;
            end
        end
    end

endmodule

[design/mrfd_checker.sv]
// port-level assertion checker for meter_response_frame_decoder
// depends on mrfd_pkg; bound to the top level at the end of this file

module mrfd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_ready,
    input mrfd_pkg::item_t   item,
    input logic              result_valid,
    input logic              result_ready,
    input mrfd_pkg::result_t result
);

    // a stalled result transaction keeps its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // voltage and energy readings only move with a good frame being shown
    a_reading_change: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(result.voltage_tenths) || !$stable(result.energy_hundredth_kwh)
        |-> result_valid && (result.frame_status == mrfd_pkg::STATUS_GOOD))
        else $error("readings changed without a good frame");

    // status is never the unused code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.frame_status == mrfd_pkg::STATUS_GOOD)
                      || (result.frame_status == mrfd_pkg::STATUS_BAD_LENGTH)
                      || (result.frame_status == mrfd_pkg::STATUS_BAD_CHECK))
        else $error("illegal frame status");

    // result valid drops only after a transaction
    a_result_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(result_valid) |-> $past(result_ready))
        else $error("result dropped without transaction");

    // input side can always move once the result side is free and empty
    a_item_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid && $past(!result_valid) && $past(!result_valid, 2) |-> item_ready)
        else $error("input stalled with empty pipeline");

endmodule

bind meter_response_frame_decoder mrfd_checker u_mrfd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
